// ===== hdl/ipfix_hrr_pkg.sv =====
package ipfix_hrr_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned IN_DATA_W   = 2 * HALF_W + 3 * WORD_W;
    localparam int unsigned OUT_DATA_W  = HALF_W + 3 * WORD_W;

    localparam logic [HALF_W-1:0] HDR_VERSION = 16'd10;
    localparam logic [HALF_W-1:0] HDR_MIN_LEN = 16'd16;
    localparam logic [WORD_W-1:0] GAP_RESET   = 32'd256;
    localparam logic [WORD_W-1:0] SIGN_BIT32  = 32'h8000_0000;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_VERSION = 2'd1,
        STATUS_SHORT_LEN   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOMAIN_REWRITE_EN = 2'd0,
        CFG_DOMAIN_VALUE      = 2'd1,
        CFG_AUTOUPDATE_EN     = 2'd2,
        CFG_SEQ_PASS_GAP      = 2'd3
    } cfg_index_t;

    // a is behind b in wraparound order
    function automatic logic behind(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] diff;
        diff = a - b;
        return (a != b) && ((diff & SIGN_BIT32) != '0);
    endfunction

endpackage

// ===== hdl/ipfix_header_replay_rewriter_core.sv =====
// IPFIX message header rewriter for replayed streams. One header word enters per cycle on the
// s_ side and one result word leaves per cycle on the m_ side while m_tready holds high; each
// header passes an input register, then a result register, and the block sustains one header
// per cycle unless the m_ side stalls. Headers with a version other than 10 or a length below 16
// are flagged in m_tuser with zeroed time, sequence and domain and leave the tracking state
// untouched. With auto-update on, the first header of a pass (s_tuser high) restarts the sequence
// at the running maximum plus seq_pass_gap and the export time at the maximum plus one; the very
// first header after reset or a clear keeps its own values. Writing the auto-update register
// clears the tracking state; configure only while the block is idle.
module ipfix_header_replay_rewriter_core
    import ipfix_hrr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // version_in, length_in, export_time_in, seq_in, domain_in
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // pass_start
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // length_out, export_time_out, seq_out, domain_out
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]            m_tuser,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    // configuration
    logic              domain_rewrite_en_reg;
    logic [WORD_W-1:0] domain_value_reg;
    logic              autoupdate_en_reg;
    logic [WORD_W-1:0] seq_pass_gap_reg;

    // tracking state
    logic              first_in_pass_reg, first_in_pass_next;
    logic              first_ever_reg, first_ever_next;
    logic [WORD_W-1:0] seq_offset_reg, seq_offset_next;
    logic [WORD_W-1:0] time_offset_reg, time_offset_next;
    logic [WORD_W-1:0] seq_highest_reg, seq_highest_next;
    logic [WORD_W-1:0] time_highest_reg, time_highest_next;

    // input stage
    logic                 in_valid_reg;
    logic                 in_pass_start_reg;
    logic [IN_DATA_W-1:0] in_data_reg;

    // result stage
    logic              out_valid_reg;
    status_t           out_status_reg, out_status_next;
    logic [HALF_W-1:0] out_length_reg;
    logic [WORD_W-1:0] out_time_reg, out_time_next;
    logic [WORD_W-1:0] out_seq_reg, out_seq_next;
    logic [WORD_W-1:0] out_domain_reg, out_domain_next;

    logic              advance;
    logic              commit;
    logic [HALF_W-1:0] version_in;
    logic [HALF_W-1:0] length_in;
    logic [WORD_W-1:0] time_in;
    logic [WORD_W-1:0] seq_in;
    logic [WORD_W-1:0] domain_in;
    logic              clear_tracking;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign commit   = in_valid_reg && advance;

    assign version_in = in_data_reg[HALF_W-1:0];
    assign length_in  = in_data_reg[2*HALF_W-1:HALF_W];
    assign time_in    = in_data_reg[2*HALF_W+WORD_W-1:2*HALF_W];
    assign seq_in     = in_data_reg[2*HALF_W+2*WORD_W-1:2*HALF_W+WORD_W];
    assign domain_in  = in_data_reg[2*HALF_W+3*WORD_W-1:2*HALF_W+2*WORD_W];

    assign clear_tracking = cfg_we && (cfg_index_t'(cfg_index) == CFG_AUTOUPDATE_EN);

    always_comb
    begin
        logic              pass_open;
        logic [WORD_W-1:0] seq_off;
        logic [WORD_W-1:0] time_off;
        logic [WORD_W-1:0] seq_hi;
        logic [WORD_W-1:0] time_hi;

        first_in_pass_next = first_in_pass_reg;
        first_ever_next    = first_ever_reg;
        seq_offset_next    = seq_offset_reg;
        time_offset_next   = time_offset_reg;
        seq_highest_next   = seq_highest_reg;
        time_highest_next  = time_highest_reg;

        pass_open = first_in_pass_reg || in_pass_start_reg;
        seq_off   = seq_offset_reg;
        time_off  = time_offset_reg;
        seq_hi    = seq_highest_reg;
        time_hi   = time_highest_reg;

        out_time_next   = time_in;
        out_seq_next    = seq_in;
        out_domain_next = domain_rewrite_en_reg ? domain_value_reg : domain_in;

        if (version_in != HDR_VERSION)
        begin
            out_status_next = STATUS_BAD_VERSION;
        end
        else if (length_in < HDR_MIN_LEN)
        begin
            out_status_next = STATUS_SHORT_LEN;
        end
        else
        begin
            out_status_next = STATUS_OK;
        end

        if (out_status_next == STATUS_OK)
        begin
            first_in_pass_next = pass_open;
            if (autoupdate_en_reg)
            begin
                if (pass_open)
                begin
                    first_in_pass_next = 1'b0;
                    if (first_ever_reg)
                    begin
                        first_ever_next = 1'b0;
                        seq_off         = '0;
                        time_off        = '0;
                        seq_hi          = seq_in;
                        time_hi         = time_in;
                    end
                    else
                    begin
                        // new pass lands just above the running maxima
                        seq_hi   = seq_highest_reg + seq_pass_gap_reg;
                        time_hi  = time_highest_reg + 32'd1;
                        seq_off  = seq_hi - seq_in;
                        time_off = time_hi - time_in;
                    end
                end
                out_time_next = time_in + time_off;
                out_seq_next  = seq_in + seq_off;
                if (behind(time_hi, out_time_next))
                begin
                    time_hi = out_time_next;
                end
                if (behind(seq_hi, out_seq_next))
                begin
                    seq_hi = out_seq_next;
                end
                seq_offset_next   = seq_off;
                time_offset_next  = time_off;
                seq_highest_next  = seq_hi;
                time_highest_next = time_hi;
            end
        end
        else
        begin
            out_time_next   = '0;
            out_seq_next    = '0;
            out_domain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            domain_rewrite_en_reg <= 1'b0;
            domain_value_reg      <= '0;
            autoupdate_en_reg     <= 1'b0;
            seq_pass_gap_reg      <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DOMAIN_REWRITE_EN: domain_rewrite_en_reg <= cfg_data[0];
                CFG_DOMAIN_VALUE:      domain_value_reg      <= cfg_data;
                CFG_AUTOUPDATE_EN:     autoupdate_en_reg     <= cfg_data[0];
                CFG_SEQ_PASS_GAP:      seq_pass_gap_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_in_pass_reg <= 1'b1;
            first_ever_reg    <= 1'b1;
            seq_offset_reg    <= '0;
            time_offset_reg   <= '0;
            seq_highest_reg   <= '0;
            time_highest_reg  <= '0;
        end
        else if (clear_tracking)
        begin
            first_in_pass_reg <= 1'b1;
            first_ever_reg    <= 1'b1;
            seq_offset_reg    <= '0;
            time_offset_reg   <= '0;
            seq_highest_reg   <= '0;
            time_highest_reg  <= '0;
        end
        else if (commit)
        begin
            first_in_pass_reg <= first_in_pass_next;
            first_ever_reg    <= first_ever_next;
            seq_offset_reg    <= seq_offset_next;
            time_offset_reg   <= time_offset_next;
            seq_highest_reg   <= seq_highest_next;
            time_highest_reg  <= time_highest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pass_start_reg <= s_tuser;
            in_data_reg       <= s_tdata;
        end
        if (commit)
        begin
            out_status_reg <= out_status_next;
            out_length_reg <= length_in;
            out_time_reg   <= out_time_next;
            out_seq_reg    <= out_seq_next;
            out_domain_reg <= out_domain_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_domain_reg, out_seq_reg, out_time_reg, out_length_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== sim/tb_ipfix_header_replay_rewriter_core.sv =====
module tb_ipfix_header_replay_rewriter_core;
    import ipfix_hrr_pkg::*;

    typedef struct {
        bit                pass_start;
        logic [HALF_W-1:0] version;
        logic [HALF_W-1:0] length;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] domain;
    } hdr_t;

    typedef struct {
        status_t           status;
        logic [HALF_W-1:0] length;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] domain;
    } rewritten_t;

    localparam int unsigned STALL_LIMIT = 1000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // version_in, length_in, export_time_in, seq_in, domain_in
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    // pass_start
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // length_out, export_time_out, seq_out, domain_out
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [1:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data  = '0;

    // register mirror
    bit                dom_rewrite = 1'b0;
    logic [WORD_W-1:0] dom_value   = '0;
    bit                auto_update = 1'b0;
    logic [WORD_W-1:0] seq_gap     = GAP_RESET;

    // tracking state mirror
    bit                new_pass   = 1'b1;
    bit                never_seen = 1'b1;
    logic [WORD_W-1:0] seq_ofs    = '0;
    logic [WORD_W-1:0] time_ofs   = '0;
    logic [WORD_W-1:0] seq_max    = '0;
    logic [WORD_W-1:0] time_max   = '0;

    hdr_t        hdr_backlog[$];
    rewritten_t  predicted_hdrs[$];
    int unsigned items_queued  = 0;
    int unsigned results_seen  = 0;
    int unsigned hdrs_rejected = 0;
    int unsigned passes_begun  = 0;
    int unsigned error_count   = 0;
    int unsigned stall_cycles  = 0;
    bit          in_fire       = 1'b0;
    bit          no_idle       = 1'b0;

    ipfix_header_replay_rewriter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // a lags b in wraparound order
    function automatic bit lags(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] d;
        d = a - b;
        return (a != b) && d[WORD_W-1];
    endfunction

    function automatic rewritten_t rewrite_header(hdr_t h);
        rewritten_t r;
        r.length = h.length;
        r.stamp  = '0;
        r.seq    = '0;
        r.domain = '0;
        if (h.version != HDR_VERSION)
        begin
            r.status = STATUS_BAD_VERSION;
            return r;
        end
        if (h.length < HDR_MIN_LEN)
        begin
            r.status = STATUS_SHORT_LEN;
            return r;
        end
        r.status = STATUS_OK;
        if (h.pass_start)
            new_pass = 1'b1;
        r.domain = dom_rewrite ? dom_value : h.domain;
        r.stamp  = h.stamp;
        r.seq    = h.seq;
        if (auto_update)
        begin
            if (new_pass)
            begin
                new_pass = 1'b0;
                if (never_seen)
                begin
                    never_seen = 1'b0;
                    seq_ofs    = '0;
                    time_ofs   = '0;
                    seq_max    = h.seq;
                    time_max   = h.stamp;
                end
                else
                begin
                    // restart just above the running maxima
                    seq_ofs  = seq_max - h.seq + seq_gap;
                    time_ofs = time_max - h.stamp + 32'd1;
                    seq_max  = h.seq + seq_ofs;
                    time_max = h.stamp + time_ofs;
                end
            end
            r.stamp = h.stamp + time_ofs;
            r.seq   = h.seq + seq_ofs;
            if (lags(time_max, r.stamp))
                time_max = r.stamp;
            if (lags(seq_max, r.seq))
                seq_max = r.seq;
        end
        return r;
    endfunction

    // driver: a word stays valid until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (hdr_backlog.size() > 0 && (no_idle || $urandom_range(0, 99) >= 33))
            begin
                hdr_t h;
                h = hdr_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= h.pass_start;
                s_tdata  <= {h.domain, h.seq, h.stamp, h.length, h.version};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= rst_n && (no_idle || $urandom_range(0, 99) >= 33);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        hdr_t       h;
        rewritten_t want;
        bit         out_fire;
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (in_fire)
        begin
            h.pass_start = s_tuser;
            h.version    = s_tdata[15:0];
            h.length     = s_tdata[31:16];
            h.stamp      = s_tdata[63:32];
            h.seq        = s_tdata[95:64];
            h.domain     = s_tdata[127:96];
            want = rewrite_header(h);
            if (want.status != STATUS_OK)
                hdrs_rejected++;
            else if (h.pass_start)
                passes_begun++;
            predicted_hdrs.push_back(want);
        end
        if (out_fire)
        begin
            if (predicted_hdrs.size() == 0)
            begin
                report_mismatch("unexpected word, status", WORD_W'(m_tuser), '0);
            end
            else
            begin
                want = predicted_hdrs.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", WORD_W'(m_tuser), WORD_W'(want.status));
                if (m_tdata[15:0] !== want.length)
                    report_mismatch("length_out", WORD_W'(m_tdata[15:0]), WORD_W'(want.length));
                if (m_tdata[47:16] !== want.stamp)
                    report_mismatch("export_time_out", m_tdata[47:16], want.stamp);
                if (m_tdata[79:48] !== want.seq)
                    report_mismatch("seq_out", m_tdata[79:48], want.seq);
                if (m_tdata[111:80] !== want.domain)
                    report_mismatch("domain_out", m_tdata[111:80], want.domain);
            end
            results_seen++;
        end
        if (in_fire || out_fire || results_seen == items_queued)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_hdr(bit ps, logic [HALF_W-1:0] ver, logic [HALF_W-1:0] len,
                           logic [WORD_W-1:0] t, logic [WORD_W-1:0] s, logic [WORD_W-1:0] d);
        hdr_t h;
        h.pass_start = ps;
        h.version    = ver;
        h.length     = len;
        h.stamp      = t;
        h.seq        = s;
        h.domain     = d;
        hdr_backlog.push_back(h);
        items_queued++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DOMAIN_REWRITE_EN: dom_rewrite = val[0];
            CFG_DOMAIN_VALUE:      dom_value = val;
            CFG_AUTOUPDATE_EN:
            begin
                // any write wipes the tracking state
                new_pass    = 1'b1;
                never_seen  = 1'b1;
                seq_ofs     = '0;
                time_ofs    = '0;
                seq_max     = '0;
                time_max    = '0;
                auto_update = val[0];
            end
            CFG_SEQ_PASS_GAP:      seq_gap = val;
            default:               ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mostly replayed passes of a stream, with broken headers and noise mixed in
    task automatic queue_replay(int unsigned n);
        int unsigned       sent;
        int unsigned       plen;
        logic [WORD_W-1:0] file_seq;
        logic [WORD_W-1:0] file_time;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] t;
        logic [HALF_W-1:0] ver;
        logic [HALF_W-1:0] len;
        sent      = 0;
        file_seq  = $urandom;
        file_time = $urandom;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                plen = $urandom_range(1, 12);
                if ($urandom_range(0, 99) < 70)
                begin
                    s = file_seq;
                    t = file_time;
                end
                else
                begin
                    s = $urandom;
                    t = $urandom;
                end
                for (int k = 0; k < plen; k++)
                begin
                    ver = HDR_VERSION;
                    len = ($urandom_range(0, 3) == 0) ? HDR_MIN_LEN
                        : HALF_W'($urandom_range(HDR_MIN_LEN, 16'hFFFF));
                    case ($urandom_range(0, 19))
                        0: ver = HALF_W'($urandom);
                        1: len = HALF_W'($urandom_range(0, HDR_MIN_LEN - 1));
                        default: ;
                    endcase
                    add_hdr((k == 0) && ($urandom_range(0, 9) != 0), ver, len, t, s, $urandom);
                    s += $urandom_range(0, 64);
                    t += $urandom_range(0, 2);
                end
                sent += plen;
            end
            else
            begin
                ver = ($urandom_range(0, 1) != 0) ? HDR_VERSION : HALF_W'($urandom);
                add_hdr(1'($urandom_range(0, 1)), ver, HALF_W'($urandom),
                        $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: pass-through, status priority and field extremes
        add_hdr(1'b0, HDR_VERSION, HDR_MIN_LEN, '0, '0, '0);
        add_hdr(1'b1, HDR_VERSION, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_hdr(1'b0, HDR_VERSION, HDR_MIN_LEN - 16'd1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1);
        add_hdr(1'b0, 16'h0000, 16'h0000, 32'h1, 32'h2, 32'h3);
        add_hdr(1'b1, 16'hFFFF, HDR_MIN_LEN, 32'h5, 32'h6, 32'h7);
        add_hdr(1'b0, 16'd11, 16'd100, 32'h8, 32'h9, 32'hA);
        add_hdr(1'b0, 16'd9, 16'd20, 32'hB, 32'hC, 32'hD);
        wait_drained();

        write_reg(CFG_DOMAIN_REWRITE_EN, 32'd1);
        write_reg(CFG_DOMAIN_VALUE, 32'hA5A5_5A5A);
        write_reg(CFG_SEQ_PASS_GAP, GAP_RESET);
        write_reg(CFG_AUTOUPDATE_EN, 32'd1);
        // first header ever, then a pass, a rejected rewind, and a real rewind
        add_hdr(1'b0, HDR_VERSION, 16'd40, 32'd1000, 32'd5000, 32'h11);
        add_hdr(1'b0, HDR_VERSION, 16'd40, 32'd1001, 32'd5010, 32'h12);
        add_hdr(1'b0, HDR_VERSION, 16'd40, 32'd999, 32'd5005, 32'h13);
        add_hdr(1'b1, 16'd9, 16'd40, 32'd1000, 32'd5000, 32'h14);
        add_hdr(1'b0, HDR_VERSION, 16'd40, 32'd1002, 32'd5020, 32'h15);
        add_hdr(1'b1, HDR_VERSION, 16'd40, 32'd1000, 32'd5000, 32'h16);
        add_hdr(1'b0, HDR_VERSION, 16'd40, 32'd1001, 32'd5001, 32'h17);
        // half the circle ahead sits right on the wraparound edge
        add_hdr(1'b0, HDR_VERSION, 16'd40, 32'h8000_03F3, 32'h8000_139D, 32'h18);
        add_hdr(1'b1, HDR_VERSION, HDR_MIN_LEN - 16'd1, 32'd7, 32'd7, 32'h19);
        add_hdr(1'b1, HDR_VERSION, HDR_MIN_LEN, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 32'h1A);
        add_hdr(1'b0, HDR_VERSION, HDR_MIN_LEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1B);
        wait_drained();

        write_reg(CFG_SEQ_PASS_GAP, 32'hFFFF_FFFF);
        write_reg(CFG_DOMAIN_REWRITE_EN, 32'd0);
        add_hdr(1'b1, HDR_VERSION, 16'd64, '0, '0, 32'h1C);
        add_hdr(1'b0, HDR_VERSION, 16'd64, 32'd3, 32'd3, 32'h1D);
        add_hdr(1'b1, HDR_VERSION, 16'd64, '0, '0, 32'h1E);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_DOMAIN_REWRITE_EN, p % 2);
            write_reg(CFG_DOMAIN_VALUE, (p == 2) ? 32'h0 : ((p == 3) ? 32'hFFFF_FFFF : $urandom));
            case (p)
                0:       write_reg(CFG_SEQ_PASS_GAP, 32'h0);
                1:       write_reg(CFG_SEQ_PASS_GAP, 32'hFFFF_FFFF);
                2:       write_reg(CFG_SEQ_PASS_GAP, GAP_RESET);
                3:       write_reg(CFG_SEQ_PASS_GAP, $urandom_range(1, 1000));
                default: write_reg(CFG_SEQ_PASS_GAP, $urandom);
            endcase
            write_reg(CFG_AUTOUPDATE_EN, (p == 3) ? 32'd0 : 32'd1);
            no_idle = (p == 4);
            queue_replay(190);
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (10) @(negedge clk);
        if (predicted_hdrs.size() != 0)
            report_mismatch("results never delivered, count", '0, predicted_hdrs.size());
        $display("checked %0d headers: %0d rejected, %0d accepted pass restarts",
                 results_seen, hdrs_rejected, passes_begun);
        $display("register settings covered gap 0, 256 and all-ones, rewrite on/off, ",
                 "auto-update on/off");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ipfix_hrr_pkg.sv
hdl/ipfix_header_replay_rewriter_core.sv
sim/tb_ipfix_header_replay_rewriter_core.sv
